// ===== hdl/ps2mct_pkg.sv =====
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned OUT_W   = 48;

    // Register indexes of the configuration port
    typedef enum logic [0:0] {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } cfg_reg_t;

    localparam logic [COORD_W-1:0] X_LIMIT_RST = 10'd319;
    localparam logic [COORD_W-1:0] Y_LIMIT_RST = 10'd239;

    // Protocol bytes
    localparam logic [BYTE_W-1:0] BAT_OK_BYTE   = 8'hAA;
    localparam logic [BYTE_W-1:0] DEVICE_ID_0   = 8'h00;
    localparam logic [3:0]        HDR_NIBBLE_LT = 4'hA;

    // Header bit positions
    localparam int unsigned HDR_LEFT_BIT = 0;
    localparam int unsigned HDR_SYNC_BIT = 3;
    localparam int unsigned HDR_XSGN_BIT = 4;
    localparam int unsigned HDR_YSGN_BIT = 5;

    // One decoded result beat
    typedef struct packed {
        logic               left_drag;
        logic               left_press;
        logic               left_down;
        logic [COORD_W-1:0] old_y;
        logic [COORD_W-1:0] old_x;
        logic [COORD_W-1:0] cursor_y;
        logic [COORD_W-1:0] cursor_x;
        logic               moved;
        logic               send_enable;
    } result_t;

    // Clamp a signed sum into 0..lim
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [COORD_W+1:0] v,
        input logic [COORD_W-1:0]        lim
    );
        logic [COORD_W+1:0] lim_ext;
        lim_ext = {2'b00, lim};
        if (v < 0)
            return '0;
        else if ($unsigned(v) > lim_ext)
            return lim;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

// ===== hdl/ps2mct_in_stage.sv =====
// Input register of the tracker: holds one received byte until the decoder takes it.
module ps2mct_in_stage
    import ps2mct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_byte,
    output logic              q_valid,
    output logic [BYTE_W-1:0] q_byte,
    input  logic              q_take
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign s_ready = !valid_reg || q_take;
    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;

    // Hold the beat until the decoder consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_byte;
        end
    end

endmodule

// ===== hdl/ps2mct_tracker.sv =====
// Byte window, packet decode, cursor state and result register.
module ps2mct_tracker
    import ps2mct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [BYTE_W-1:0]  in_byte,
    output logic               in_take,
    input  logic [COORD_W-1:0] x_limit,
    input  logic [COORD_W-1:0] y_limit,
    output logic               out_valid,
    output result_t            out_result,
    input  logic               out_ready
);

    logic [BYTE_W-1:0]  hdr_reg, hdr_next;
    logic [BYTE_W-1:0]  mid_reg, mid_next;
    logic [COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [COORD_W-1:0] pos_y_reg, pos_y_next;
    logic               left_reg, left_next;
    logic               valid_reg;
    result_t            result_reg, result_next;

    logic                      is_header;
    logic                      btn;
    logic signed [COORD_W+1:0] dx;
    logic signed [COORD_W+1:0] dy;
    logic signed [COORD_W+1:0] sum_x;
    logic signed [COORD_W+1:0] sum_y;
    logic                      fire;

    assign fire      = in_valid && (!valid_reg || out_ready);
    assign in_take   = fire;
    assign out_valid = valid_reg;
    assign out_result = result_reg;

    // Decode the window: two stored bytes plus the new one
    always_comb
    begin
        is_header = hdr_reg[HDR_SYNC_BIT] && (hdr_reg[7:4] < HDR_NIBBLE_LT);
        btn       = hdr_reg[HDR_LEFT_BIT];
        dx = $signed({{(COORD_W-6){hdr_reg[HDR_XSGN_BIT]}}, mid_reg});
        dy = $signed({{(COORD_W-6){hdr_reg[HDR_YSGN_BIT]}}, in_byte});
        sum_x = $signed({2'b00, pos_x_reg}) + dx;
        sum_y = $signed({2'b00, pos_y_reg}) - dy;

        hdr_next   = mid_reg;
        mid_next   = in_byte;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        left_next  = left_reg;

        result_next.send_enable = (mid_reg == BAT_OK_BYTE) && (in_byte == DEVICE_ID_0);
        result_next.moved       = 1'b0;
        result_next.left_press  = 1'b0;
        result_next.left_drag   = 1'b0;
        result_next.old_x       = pos_x_reg;
        result_next.old_y       = pos_y_reg;

        if (is_header)
        begin
            pos_x_next = clamp_coord(sum_x, x_limit);
            pos_y_next = clamp_coord(sum_y, y_limit);
            left_next  = btn;
            result_next.moved      = 1'b1;
            result_next.left_press = !left_reg && btn;
            result_next.left_drag  = left_reg && btn;
        end

        result_next.cursor_x  = pos_x_next;
        result_next.cursor_y  = pos_y_next;
        result_next.left_down = left_next;
    end

    // Advance tracker state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg   <= '0;
            mid_reg   <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            left_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                hdr_reg   <= hdr_next;
                mid_reg   <= mid_next;
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                left_reg  <= left_next;
            end
            if (fire)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    a_still_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.moved) |->
            (result_reg.cursor_x == result_reg.old_x &&
             result_reg.cursor_y == result_reg.old_y))
        else $error("cursor changed without a packet");

    a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(result_reg.left_press && result_reg.left_drag))
        else $error("press and drag in one result");

    a_edge_needs_pkt: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (result_reg.left_press || result_reg.left_drag)) |->
            (result_reg.moved && result_reg.left_down))
        else $error("button edge without a pressed packet");

    a_fire_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (valid_reg && result_reg.cursor_x == pos_x_reg &&
                  result_reg.cursor_y == pos_y_reg && result_reg.left_down == left_reg))
        else $error("result does not match tracker state");

endmodule

// ===== hdl/ps2_mouse_cursor_tracker_core.sv =====
// Top level of the PS/2 mouse cursor tracker: ports, limit registers, stages.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata[7:0] rx_byte
//  m_axis   | out | m_axis_tvalid/tready   | tdata[47:0] decoded cursor result
//  cfg      | in  | cfg_valid/cfg_ready    | cfg_index (0 x_limit, 1 y_limit), cfg_data
//
//  One byte per cycle sustained while the output is not stalled; a byte's result beat
//  is presented once the byte has passed the input register and then the single-pass
//  decode into the result register. Reset clears the byte window, cursor position and
//  button state; limits go to 319 and 239. A stalled output holds its beat while one
//  more byte waits in the input register; cfg_ready is always high.
module ps2_mouse_cursor_tracker_core
    import ps2mct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] send_enable, [1] moved, [11:2] cursor_x, [21:12] cursor_y,
    // [31:22] old_x, [41:32] old_y, [42] left_down, [43] left_press,
    // [44] left_drag, [47:45] zero
    output logic [OUT_W-1:0]   m_axis_tdata,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [COORD_W-1:0] cfg_data
);

    localparam int unsigned RES_W = $bits(result_t);

    logic [COORD_W-1:0] x_limit_reg;
    logic [COORD_W-1:0] y_limit_reg;
    logic               q_valid;
    logic [BYTE_W-1:0]  q_byte;
    logic               q_take;
    result_t            result;

    assign cfg_ready = 1'b1;

    // Write limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:     x_limit_reg <= x_limit_reg;
            endcase
        end
    end

    ps2mct_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_byte  (s_axis_tdata),
        .q_valid (q_valid),
        .q_byte  (q_byte),
        .q_take  (q_take)
    );

    ps2mct_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_byte    (q_byte),
        .in_take    (q_take),
        .x_limit    (x_limit_reg),
        .y_limit    (y_limit_reg),
        .out_valid  (m_axis_tvalid),
        .out_result (result),
        .out_ready  (m_axis_tready)
    );

    // Pack the result beat, send_enable in the lowest bit
    assign m_axis_tdata = {{(OUT_W-RES_W){1'b0}}, result};

endmodule

// ===== sim/ps2_mouse_cursor_tracker_core_test.sv =====
// Testbench for the PS/2 mouse cursor tracker: byte stimulus, cursor prediction, result checks.
module ps2_mouse_cursor_tracker_core_test;
    import ps2mct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES   = 6;
    localparam int          DRAIN_SLACK    = 4;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          PHASE_ITEMS    = 300;
    localparam logic [7:0]  HDR_CEILING    = 8'hE0;

    // Tracks cursor state and holds the results it predicts
    class cursor_scoreboard;
        logic [COORD_W-1:0] x_lim;
        logic [COORD_W-1:0] y_lim;
        logic [BYTE_W-1:0]  window_old;
        logic [BYTE_W-1:0]  window_mid;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               held;
        result_t            pending[$];
        int                 errors;
        int                 beats;
        int                 moves;
        int                 enables;
        int                 presses;
        int                 drags;
        int                 clamps;

        function new();
            x_lim      = X_LIMIT_RST;
            y_lim      = Y_LIMIT_RST;
            window_old = '0;
            window_mid = '0;
            pos_x      = '0;
            pos_y      = '0;
            held       = 1'b0;
            errors     = 0;
            beats      = 0;
            moves      = 0;
            enables    = 0;
            presses    = 0;
            drags      = 0;
            clamps     = 0;
        endfunction

        function void set_limit(cfg_reg_t r, logic [COORD_W-1:0] v);
            if (r == REG_X_LIMIT)
                x_lim = v;
            else
                y_lim = v;
        endfunction

        function logic [COORD_W-1:0] bound(int v, logic [COORD_W-1:0] lim);
            if (v < 0)
            begin
                clamps++;
                return '0;
            end
            if (v > int'(lim))
            begin
                clamps++;
                return lim;
            end
            return v[COORD_W-1:0];
        endfunction

        // Slide the byte window and predict the beat this byte causes
        function void note_byte(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] hdr;
            logic [BYTE_W-1:0] mid;
            result_t           r;
            int                dx;
            int                dy;
            hdr        = window_old;
            mid        = window_mid;
            window_old = mid;
            window_mid = b;
            r             = '0;
            r.send_enable = (mid == BAT_OK_BYTE) && (b == DEVICE_ID_0);
            r.old_x       = pos_x;
            r.old_y       = pos_y;
            if (hdr[HDR_SYNC_BIT] && hdr < HDR_CEILING && hdr[7:4] < HDR_NIBBLE_LT)
            begin
                dx = int'(mid);
                dy = int'(b);
                if (hdr[HDR_XSGN_BIT])
                    dx -= 256;
                if (hdr[HDR_YSGN_BIT])
                    dy -= 256;
                r.left_press = !held && hdr[HDR_LEFT_BIT];
                r.left_drag  = held && hdr[HDR_LEFT_BIT];
                held         = hdr[HDR_LEFT_BIT];
                pos_x        = bound(int'(pos_x) + dx, x_lim);
                pos_y        = bound(int'(pos_y) - dy, y_lim);
                r.moved      = 1'b1;
                moves++;
                if (r.left_press)
                    presses++;
                if (r.left_drag)
                    drags++;
            end
            if (r.send_enable)
                enables++;
            r.cursor_x  = pos_x;
            r.cursor_y  = pos_y;
            r.left_down = held;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [COORD_W-1:0] e, logic [COORD_W-1:0] a);
            if (a !== e)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, a);
                errors++;
            end
        endfunction

        // Compare one output beat against the oldest prediction
        function void check_result(logic [OUT_W-1:0] d);
            result_t act;
            result_t exp_r;
            act = d[$bits(result_t)-1:0];
            beats++;
            if (pending.size() == 0)
            begin
                $error("result beat with no prediction waiting");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            compare_field("send_enable", COORD_W'(exp_r.send_enable),
                          COORD_W'(act.send_enable));
            compare_field("moved", COORD_W'(exp_r.moved), COORD_W'(act.moved));
            compare_field("cursor_x", exp_r.cursor_x, act.cursor_x);
            compare_field("cursor_y", exp_r.cursor_y, act.cursor_y);
            compare_field("old_x", exp_r.old_x, act.old_x);
            compare_field("old_y", exp_r.old_y, act.old_y);
            compare_field("left_down", COORD_W'(exp_r.left_down), COORD_W'(act.left_down));
            compare_field("left_press", COORD_W'(exp_r.left_press),
                          COORD_W'(act.left_press));
            compare_field("left_drag", COORD_W'(exp_r.left_drag), COORD_W'(act.left_drag));
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index     = '0;
    logic [COORD_W-1:0] cfg_data      = '0;

    cursor_scoreboard sb = new();

    int burst_left     = 0;
    int bytes_sent     = 0;
    int limit_settings = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    int ready_mode     = 0;
    int mode_cycles    = 0;

    ps2_mouse_cursor_tracker_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Check result beats and stall the output on a pattern that changes mode
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        mode_cycles++;
        if (mode_cycles >= 250)
        begin
            mode_cycles = 0;
            ready_mode  = $urandom_range(0, 3);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2:
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        stall_left = $urandom_range(0, 14);
                        m_axis_tready <= 1'b0;
                    end
                    else
                        m_axis_tready <= 1'b1;
                end
                3: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // End the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Offer one byte, opening a random gap when the current burst runs out
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
            gap        = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Hold the input until every predicted beat has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Write both limits back to back, valid held high across the two beats
    task automatic write_limits(input logic [COORD_W-1:0] xv, input logic [COORD_W-1:0] yv);
        cfg_valid <= 1'b1;
        cfg_index <= REG_X_LIMIT;
        cfg_data  <= xv;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_limit(REG_X_LIMIT, xv);
        cfg_index <= REG_Y_LIMIT;
        cfg_data  <= yv;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_limit(REG_Y_LIMIT, yv);
        cfg_valid <= 1'b0;
        limit_settings++;
    endtask

    // Header byte: sync bit set, upper nibble 0..9, other bits random
    function automatic logic [7:0] make_header();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom_range(0, 9));
        lo = 4'($urandom_range(0, 15));
        lo[HDR_SYNC_BIT] = 1'b1;
        return {hi, lo};
    endfunction

    // Drain, set new limits, then stream mostly well-formed packets
    task automatic run_phase(input logic [COORD_W-1:0] xv, input logic [COORD_W-1:0] yv);
        int start;
        int kind;
        int n;
        drain();
        write_limits(xv, yv);
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                send_packet(make_header(), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
            else if (kind == 6)
                // small moves keep the cursor away from the bounds for a while
                send_packet(make_header(), 8'($urandom_range(0, 1) ? $urandom_range(0, 7)
                            : $urandom_range(248, 255)), 8'($urandom_range(0, 1) ?
                            $urandom_range(0, 7) : $urandom_range(248, 255)));
            else if (kind == 7)
            begin
                if ($urandom_range(0, 1))
                    send_packet(make_header(), BAT_OK_BYTE, DEVICE_ID_0);
                else
                begin
                    send_byte(BAT_OK_BYTE);
                    send_byte(DEVICE_ID_0);
                end
            end
            else if (kind == 8)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                // broken packet: header and one data byte only
                send_byte(make_header());
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        logic [7:0] opening[24] = '{
            8'h08, 8'h00, 8'h00,
            8'h09, 8'h7F, 8'h00,
            8'h09, 8'hFF, 8'h7F,
            8'h38, 8'h00, 8'h80,
            8'h9F, 8'h01, 8'hFF,
            8'h08, 8'hAA, 8'h00,
            8'hA8, 8'hF8, 8'h07,
            8'hAA, 8'h00, 8'hFF
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed bytes under the reset limits
        foreach (opening[i])
            send_byte(opening[i]);

        // Random phases, each behind a full drain and a limit change
        run_phase(10'd1023, 10'd1023);
        run_phase(10'd100, 10'd60);
        run_phase(10'd0, 10'd0);
        run_phase(10'd319, 10'd239);
        run_phase(10'd1023, 10'd5);
        run_phase(10'($urandom_range(1, 1022)), 10'($urandom_range(1, 1022)));
        run_phase(10'd700, 10'd1023);
        drain();

        if (sb.pending.size() != 0)
        begin
            $error("%0d predicted beats never came out", sb.pending.size());
            sb.errors++;
        end
        $display("sent %0d bytes over %0d limit settings, checked %0d beats",
                 bytes_sent, limit_settings, sb.beats);
        $display("%0d cursor updates (%0d clamped), %0d enable requests, %0d presses, %0d drags",
                 sb.moves, sb.clamps, sb.enables, sb.presses, sb.drags);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ps2mct_pkg.sv
hdl/ps2mct_in_stage.sv
hdl/ps2mct_tracker.sv
hdl/ps2_mouse_cursor_tracker_core.sv
sim/ps2_mouse_cursor_tracker_core_test.sv
